// File: hw/rtl/dfr_pkg.sv
// shared constants, codes and control types of the delimited frame receiver
package dfr_pkg;

  // frame store geometry
  localparam int FRAME_MAX = 32;
  localparam int ADDR_W    = $clog2(FRAME_MAX);
  localparam int CNT_W     = $clog2(FRAME_MAX + 1);

  // field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int MIN_W  = 5;
  localparam int CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN    = 2'd2;

  localparam logic [BYTE_W-1:0] START_CODE_RST = 8'hF1;
  localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'hF2;
  localparam logic [MIN_W-1:0]  MIN_LEN_RST    = 5'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPEN,
    ST_READ,
    ST_LOAD,
    ST_SEND
  } dfr_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic wr_start;   // store first byte, fill count to one
    logic wr_data;    // store data byte, bump fill count
    logic wr_end;     // store end code, latch length, rewind read index
    logic clr_fill;   // drop the open frame
    logic rd_en;      // read frame store at read index
    logic ld_out;     // capture read data into output register
    logic adv;        // step read index after an output transaction
  } dfr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_start;   // input byte matches start code
    logic is_end;     // input byte matches end code
    logic close_ok;   // enough bytes stored to accept the frame
    logic room;       // a data byte still leaves room for the end code
    logic out_last;   // output register holds the final byte
  } dfr_status_t;

endpackage

// File: hw/rtl/dfr_rx_if.sv
// input channel: one received serial byte per transaction
interface dfr_rx_if import dfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/dfr_frame_if.sv
// result channel: one byte of a completed frame per transaction
interface dfr_frame_if import dfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic [LEN_W-1:0]  frame_len;
  logic              last;

  modport source (output valid, output frame_byte, output frame_len, output last,
                  input ready);
  modport sink   (input valid, input frame_byte, input frame_len, input last,
                  output ready);
endinterface

// File: hw/rtl/dfr_ram.sv
// generic single-port-write ram with registered read
module dfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/dfr_datapath.sv
// datapath: configuration registers, fill count, frame store and output register
module dfr_datapath import dfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [BYTE_W-1:0]     rx_byte,
  input  dfr_cmd_t              cmd,
  output dfr_status_t           status,
  output logic [BYTE_W-1:0]     frame_byte,
  output logic [LEN_W-1:0]      frame_len,
  output logic                  last
);

  logic [BYTE_W-1:0] start_code_r, start_code_nxt;
  logic [BYTE_W-1:0] end_code_r, end_code_nxt;
  logic [MIN_W-1:0]  min_len_r, min_len_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_rdata;

  // configuration registers
  always_comb begin
    start_code_nxt = start_code_r;
    end_code_nxt   = end_code_r;
    min_len_nxt    = min_len_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_START_CODE: start_code_nxt = cfg_data[BYTE_W-1:0];
        REG_END_CODE:   end_code_nxt   = cfg_data[BYTE_W-1:0];
        REG_MIN_LEN:    min_len_nxt    = cfg_data[MIN_W-1:0];
        default:        ;
      endcase
    end
  end

  // fill count, frame length and read index
  always_comb begin
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    rd_idx_nxt = rd_idx_r;
    if (cmd.wr_start) begin
      fill_nxt = CNT_W'(1);
    end else if (cmd.wr_data) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (cmd.wr_end) begin
      fill_nxt   = '0;
      len_nxt    = fill_r + CNT_W'(1);
      rd_idx_nxt = '0;
    end else if (cmd.clr_fill) begin
      fill_nxt = '0;
    end
    if (cmd.adv) begin
      rd_idx_nxt = rd_idx_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= START_CODE_RST;
      end_code_r   <= END_CODE_RST;
      min_len_r    <= MIN_LEN_RST;
      fill_r       <= '0;
      len_r        <= '0;
      rd_idx_r     <= '0;
    end else begin
      start_code_r <= start_code_nxt;
      end_code_r   <= end_code_nxt;
      min_len_r    <= min_len_nxt;
      fill_r       <= fill_nxt;
      len_r        <= len_nxt;
      rd_idx_r     <= rd_idx_nxt;
    end
  end

  // frame store
  assign ram_we    = cmd.wr_start | cmd.wr_data | cmd.wr_end;
  assign ram_waddr = cmd.wr_start ? '0 : fill_r[ADDR_W-1:0];

  dfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_MAX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rx_byte),
    .re    (cmd.rd_en),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_byte_r <= ram_rdata;
      out_last_r <= (CNT_W'(rd_idx_r) + CNT_W'(1)) == len_r;
    end
  end

  assign frame_byte = out_byte_r;
  assign frame_len  = LEN_W'(len_r);
  assign last       = out_last_r;

  // status
  assign status.is_start = rx_byte == start_code_r;
  assign status.is_end   = rx_byte == end_code_r;
  assign status.close_ok = (CMP_W'(fill_r) >= CMP_W'(min_len_r)) &&
                           (fill_r < CNT_W'(FRAME_MAX));
  assign status.room     = fill_r <= CNT_W'(FRAME_MAX - 2);
  assign status.out_last = out_last_r;

endmodule

// File: hw/rtl/dfr_ctrl.sv
// controller: frame state machine and channel handshakes
module dfr_ctrl import dfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        out_ready,
  input  dfr_status_t status,
  output logic        in_ready,
  output logic        out_valid,
  output dfr_cmd_t    cmd
);

  dfr_state_t state_r, state_nxt;
  logic       in_take;

  assign in_take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && status.is_start) begin
          state_nxt = ST_OPEN;
        end
      end
      ST_OPEN: begin
        if (in_valid && !status.is_start) begin
          if (status.is_end) begin
            state_nxt = status.close_ok ? ST_READ : ST_IDLE;
          end else if (!status.room) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_ready) begin
          state_nxt = status.out_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_take) begin
          if (status.is_start) begin
            cmd.wr_start = 1'b1;
          end else if (status.is_end) begin
            cmd.clr_fill = 1'b1;
          end
        end
      end
      ST_OPEN: begin
        in_ready = 1'b1;
        if (in_take && !status.is_start) begin
          if (status.is_end) begin
            cmd.wr_end   = status.close_ok;
            cmd.clr_fill = !status.close_ok;
          end else begin
            cmd.wr_data  = status.room;
            cmd.clr_fill = !status.room;
          end
        end
      end
      ST_READ: cmd.rd_en  = 1'b1;
      ST_LOAD: cmd.ld_out = 1'b1;
      ST_SEND: begin
        out_valid = 1'b1;
        cmd.adv   = out_ready;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/delimited_frame_receiver_top.sv
// top level of the delimited frame receiver
// A byte stream comes in one byte per transaction. While idle, a start code
// opens a frame; bytes up to the end code are kept in a FRAME_MAX-byte frame
// store. An end code closes the frame and, if at least min_len bytes were
// stored, the whole frame (start and end codes included) goes out one byte per
// transaction with its total length and the last byte flagged. Short frames,
// frames that would outgrow FRAME_MAX, a stray end code while idle and any data
// while idle produce nothing. Input is taken back to back while no frame is
// being sent. Once an accepted end code closes a frame, input is held off
// until its last byte leaves; each byte passes through a frame store read,
// an output register load and an output transaction, and output backpressure
// stretches the stall further. The registered read of the frame store is why
// the read and the load are separate steps. No clearing pass after reset:
// only bytes written in the current frame are read back. Configuration writes
// go to start_code (index 0), end_code (index 1) and min_len (index 2); other
// indexes are ignored, and writes are meant for times when no frame is open or
// in flight.
module delimited_frame_receiver_top import dfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dfr_rx_if.sink                in_ch,
  dfr_frame_if.source           out_ch
);

  // command and status between controller and datapath
  dfr_cmd_t    cmd;
  dfr_status_t status;

  // frame state machine: owns both handshakes
  dfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // registers, byte compare, frame store and output payload
  dfr_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_byte    (in_ch.rx_byte),
    .cmd        (cmd),
    .status     (status),
    .frame_byte (out_ch.frame_byte),
    .frame_len  (out_ch.frame_len),
    .last       (out_ch.last)
  );

endmodule
